FILE: rtl/randomized_hadamard_transform_top_macros.svh
// Assertion macros used by the back end of the randomized Hadamard transform RTL
`ifndef RANDOMIZED_HADAMARD_TRANSFORM_TOP_MACROS_SVH
`define RANDOMIZED_HADAMARD_TRANSFORM_TOP_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define RHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequent in the cycle after its antecedent
`define RHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rht_pkg.sv
// Shared constants, types and helper functions of the randomized Hadamard transform
`timescale 1ns / 1ps

package rht_pkg;

	localparam int MAX_LEN     = 64;
	localparam int ADDR_W      = $clog2(MAX_LEN);
	localparam int MAX_LOG     = $clog2(MAX_LEN + 1) - 1;
	localparam int LOG_W       = 3;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int ACC_W       = SAMPLE_BITS + MAX_LOG + 1;
	localparam int OUT_W       = 20;
	localparam int SCALE_W     = 17;
	localparam int PROD_W      = ACC_W + SCALE_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          sign_negative;
	} load_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] result;
		logic                    last_of_vector;
	} emit_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          sign_negative;
		logic [ADDR_W-1:0]             index;
		logic                          last;
	} queue_entry_t;

	typedef struct packed {
		logic [LOG_W-1:0] log2_len;
		logic             inverse;
		logic             restart;
	} cfg_t;

	function automatic logic [LOG_W-1:0] eff_log2(input logic [LOG_W-1:0] k);
		if (k > LOG_W'(MAX_LOG)) begin
			return LOG_W'(MAX_LOG);
		end
		return k;
	endfunction

	// round(65536 / sqrt(2^k))
	function automatic logic [SCALE_W-1:0] scale_q16(input logic [LOG_W-1:0] k);
		logic [SCALE_W-1:0] s;
		case (k)
			3'd0: s = 17'd65536;
			3'd1: s = 17'd46341;
			3'd2: s = 17'd32768;
			3'd3: s = 17'd23170;
			3'd4: s = 17'd16384;
			3'd5: s = 17'd11585;
			3'd6: s = 17'd8192;
			default: s = 17'd8192;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/rht_ram.sv
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps

module rht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/rht_queue.sv
// Short queue of classified samples between the front and the back
`timescale 1ns / 1ps

module rht_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rht_pkg::queue_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output rht_pkg::queue_entry_t pop_entry,
	output logic                  empty
);

	import rht_pkg::*;

	queue_entry_t      entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rht_front.sv
// Front end: accepts samples, assigns vector positions and marks the last element
`timescale 1ns / 1ps

module rht_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rht_pkg::cfg_t         cfg,
	input  logic                  load_valid,
	output logic                  load_stall,
	input  rht_pkg::load_item_t   load_item,
	output logic                  q_push,
	output rht_pkg::queue_entry_t q_entry,
	input  logic                  q_full
);

	import rht_pkg::*;

	logic [ADDR_W-1:0] count_q;
	logic [CNT_W-1:0]  len_w;
	logic [ADDR_W-1:0] last_idx;
	logic [ADDR_W-1:0] idx;
	logic              is_last;

	assign load_stall = q_full;
	assign q_push     = load_valid && !q_full;

	assign len_w    = CNT_W'(1) << cfg.log2_len;
	assign last_idx = ADDR_W'(len_w - CNT_W'(1));
	assign idx      = (count_q > last_idx) ? '0 : count_q;
	assign is_last  = (idx == last_idx);

	always_comb begin
		q_entry.sample        = load_item.sample;
		q_entry.sign_negative = load_item.sign_negative;
		q_entry.index         = idx;
		q_entry.last          = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.restart) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= is_last ? '0 : idx + 1'b1;
		end
	end

endmodule

FILE: rtl/rht_back.sv
// Back end: stores the vector, runs the butterfly stages and emits scaled results
`timescale 1ns / 1ps
`include "randomized_hadamard_transform_top_macros.svh"

module rht_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rht_pkg::cfg_t         cfg,
	output logic                  q_pop,
	input  rht_pkg::queue_entry_t q_entry,
	input  logic                  q_empty,
	output logic                  emit_valid,
	input  logic                  emit_stall,
	output rht_pkg::emit_item_t   emit_item
);

	import rht_pkg::*;

	localparam int RS_W = PROD_W - 16;
	localparam logic signed [RS_W-1:0] SAT_HI = RS_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(-(2 ** (OUT_W - 1)));
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** 15);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_BF_RD  = 3'd1;
	localparam logic [2:0] ST_BF_WR1 = 3'd2;
	localparam logic [2:0] ST_BF_WR2 = 3'd3;
	localparam logic [2:0] ST_EM_RD  = 3'd4;
	localparam logic [2:0] ST_EM_MUL = 3'd5;
	localparam logic [2:0] ST_EM_OUT = 3'd6;

	logic [2:0]              state_q;
	logic [LOG_W-1:0]        stage_q;
	logic [ADDR_W-1:0]       bfly_q;
	logic [ADDR_W-1:0]       emit_idx_q;
	logic signed [ACC_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                    emit_valid_q;
	emit_item_t              emit_item_q;

	logic [CNT_W-1:0]  len_w;
	logic [ADDR_W-1:0] half_m1;
	logic [ADDR_W-1:0] len_m1;
	logic [ADDR_W-1:0] low_mask;
	logic [ADDR_W-1:0] stride;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic              bf_active;
	logic              last_bfly;
	logic              last_stage;
	logic              last_emit;
	logic              out_free;

	logic              v_we;
	logic              s_we;
	logic [ADDR_W-1:0] waddr;
	logic [ACC_W-1:0]  v_wdata;
	logic [ADDR_W-1:0] raddr_a;
	logic [ACC_W-1:0]  v_rdata_a;
	logic [ACC_W-1:0]  v_rdata_b;
	logic              s_rdata_a;
	logic              s_rdata_b;

	logic signed [ACC_W-1:0]   ra;
	logic signed [ACC_W-1:0]   rb;
	logic signed [ACC_W-1:0]   na;
	logic signed [ACC_W-1:0]   nb;
	logic                      first_signs;
	logic signed [ACC_W-1:0]   nv;
	logic signed [SCALE_W:0]   scale_s;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  rsum;
	logic signed [RS_W-1:0]    rshift;
	logic signed [RS_W-1:0]    clamped;

	assign len_w      = CNT_W'(1) << cfg.log2_len;
	assign len_m1     = ADDR_W'(len_w - CNT_W'(1));
	assign half_m1    = ADDR_W'((len_w >> 1) - CNT_W'(1));
	assign stride     = ADDR_W'(CNT_W'(1) << stage_q);
	assign low_mask   = stride - 1'b1;
	assign addr_a     = ADDR_W'({(bfly_q & ~low_mask), 1'b0}) | (bfly_q & low_mask);
	assign addr_b     = addr_a | stride;
	assign bf_active  = state_q inside {ST_BF_RD, ST_BF_WR1, ST_BF_WR2};
	assign last_bfly  = (bfly_q == half_m1);
	assign last_stage = (stage_q == cfg.log2_len - 1'b1);
	assign last_emit  = (emit_idx_q == len_m1);
	assign out_free   = !emit_valid_q || !emit_stall;

	assign q_pop = (state_q == ST_LOAD) && !q_empty;

	always_comb begin
		v_we    = 1'b0;
		s_we    = 1'b0;
		waddr   = addr_a;
		v_wdata = ACC_W'(na + nb);
		case (state_q)
			ST_LOAD: begin
				v_we    = q_pop;
				s_we    = q_pop;
				waddr   = q_entry.index;
				v_wdata = {{(ACC_W - SAMPLE_BITS){q_entry.sample[SAMPLE_BITS-1]}},
					q_entry.sample};
			end
			ST_BF_WR1: begin
				v_we = 1'b1;
			end
			ST_BF_WR2: begin
				v_we    = 1'b1;
				waddr   = addr_b;
				v_wdata = diff_q;
			end
			default: begin
				v_we = 1'b0;
			end
		endcase
	end

	assign raddr_a = (state_q == ST_EM_RD) ? emit_idx_q : addr_a;

	rht_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_LEN)
	) u_vec_ram (
		.clk     (clk),
		.we      (v_we),
		.waddr   (waddr),
		.wdata   (v_wdata),
		.raddr_a (raddr_a),
		.raddr_b (addr_b),
		.rdata_a (v_rdata_a),
		.rdata_b (v_rdata_b)
	);

	rht_ram #(
		.WIDTH (1),
		.DEPTH (MAX_LEN)
	) u_sign_ram (
		.clk     (clk),
		.we      (s_we),
		.waddr   (waddr),
		.wdata   (q_entry.sign_negative),
		.raddr_a (raddr_a),
		.raddr_b (addr_b),
		.rdata_a (s_rdata_a),
		.rdata_b (s_rdata_b)
	);

	// forward mode applies the signs as the first stage reads its operands
	assign first_signs = (stage_q == '0) && !cfg.inverse;
	assign ra = $signed(v_rdata_a);
	assign rb = $signed(v_rdata_b);
	assign na = (first_signs && s_rdata_a) ? -ra : ra;
	assign nb = (first_signs && s_rdata_b) ? -rb : rb;

	// inverse mode, and the single-element vector, apply the sign on the way out
	assign nv      = (s_rdata_a && (cfg.inverse || cfg.log2_len == '0)) ? -ra : ra;
	assign scale_s = $signed({1'b0, scale_q16(cfg.log2_len)});
	assign prod_d  = nv * scale_s;

	assign rsum    = prod_s1 + ROUND_HALF;
	assign rshift  = $signed(rsum[PROD_W-1:16]);
	assign clamped = (rshift > SAT_HI) ? SAT_HI : ((rshift < SAT_LO) ? SAT_LO : rshift);

	always_ff @(posedge clk) begin
		if (state_q == ST_BF_WR1) begin
			diff_q <= ACC_W'(na - nb);
		end
		if (state_q == ST_EM_MUL) begin
			prod_s1 <= prod_d;
		end
		if (state_q == ST_EM_OUT && out_free) begin
			emit_item_q.result         <= OUT_W'(clamped);
			emit_item_q.last_of_vector <= last_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			stage_q      <= '0;
			bfly_q       <= '0;
			emit_idx_q   <= '0;
			emit_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EM_OUT && out_free) begin
				emit_valid_q <= 1'b1;
			end else if (emit_valid_q && !emit_stall) begin
				emit_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop && q_entry.last) begin
						stage_q    <= '0;
						bfly_q     <= '0;
						emit_idx_q <= '0;
						state_q    <= (cfg.log2_len == '0) ? ST_EM_RD : ST_BF_RD;
					end
				end
				ST_BF_RD: begin
					state_q <= ST_BF_WR1;
				end
				ST_BF_WR1: begin
					state_q <= ST_BF_WR2;
				end
				ST_BF_WR2: begin
					if (last_bfly) begin
						bfly_q <= '0;
						if (last_stage) begin
							state_q <= ST_EM_RD;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= ST_BF_RD;
						end
					end else begin
						bfly_q  <= bfly_q + 1'b1;
						state_q <= ST_BF_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_MUL;
				end
				ST_EM_MUL: begin
					state_q <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (out_free) begin
						if (last_emit) begin
							emit_idx_q <= '0;
							state_q    <= ST_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q    <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign emit_valid = emit_valid_q;
	assign emit_item  = emit_item_q;

	`RHT_ASSERT_NOW(a_bfly_in_range, bf_active,
		(bfly_q <= half_m1) && (stage_q < cfg.log2_len), "butterfly index out of range")
	`RHT_ASSERT_NOW(a_emit_from_out, $rose(emit_valid_q),
		$past(state_q) == ST_EM_OUT, "result shown without an output step")
	`RHT_ASSERT_NEXT(a_last_returns, (state_q == ST_EM_OUT) && out_free && last_emit,
		(state_q == ST_LOAD) && emit_valid_q && emit_item_q.last_of_vector,
		"final result did not end the vector")
	`RHT_ASSERT_NOW(a_last_idx_wrap, emit_valid_q && emit_item_q.last_of_vector,
		emit_idx_q == '0, "emit index not rewound after final result")

endmodule

FILE: rtl/randomized_hadamard_transform_top.sv
// Top level of the randomized Walsh-Hadamard transform: configuration registers and wiring
`timescale 1ns / 1ps

// Loads n = 2^length_log2 samples (length above 6 acts as 6) and, after the last one,
// emits n results in order with last_of_vector on the final one. Each sample transaction
// is accepted while the 4-entry queue has room. After the last sample the transform runs
// (n/2)*log2(n) butterflies, each reading both operands, writing the sum and then the
// difference through the single write port of the vector RAM, then reads, scales and
// outputs each result in turn. Samples of the next vector queue up while results are
// still being emitted.
module randomized_hadamard_transform_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rht_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               load_valid,
	output logic                               load_stall,
	input  rht_pkg::load_item_t                load_item,
	output logic                               emit_valid,
	input  logic                               emit_stall,
	output rht_pkg::emit_item_t                emit_item
);

	import rht_pkg::*;

	logic [LOG_W-1:0] length_log2_q;
	logic             inverse_mode_q;
	cfg_t             cfg;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	queue_entry_t     push_entry;
	queue_entry_t     pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_log2_q  <= LOG_W'(6);
			inverse_mode_q <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == REG_LENGTH) begin
				length_log2_q <= cfg_data[LOG_W-1:0];
			end
			if (cfg_index == REG_MODE) begin
				inverse_mode_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		cfg.log2_len = eff_log2(length_log2_q);
		cfg.inverse  = inverse_mode_q;
		cfg.restart  = cfg_write && (cfg_index == REG_LENGTH);
	end

	rht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.load_valid (load_valid),
		.load_stall (load_stall),
		.load_item  (load_item),
		.q_push     (q_push),
		.q_entry    (push_entry),
		.q_full     (q_full)
	);

	rht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	rht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_pop      (q_pop),
		.q_entry    (pop_entry),
		.q_empty    (q_empty),
		.emit_valid (emit_valid),
		.emit_stall (emit_stall),
		.emit_item  (emit_item)
	);

endmodule

FILE: bench/tb_randomized_hadamard_transform_top.sv
// Self-checking testbench for the randomized Walsh-Hadamard transform top level
`timescale 1ns / 1ps

module tb_randomized_hadamard_transform_top;

	import rht_pkg::*;

	localparam int LOG_MAX        = 6;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 230;
	localparam logic [CFG_DATA_W-1:0] MODE_FORWARD = '0;
	localparam logic [CFG_DATA_W-1:0] MODE_INVERSE = CFG_DATA_W'(1);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  load_valid;
	logic                  load_stall;
	load_item_t            load_item;
	logic                  emit_valid;
	logic                  emit_stall;
	emit_item_t            emit_item;

	randomized_hadamard_transform_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load_valid(load_valid),
		.load_stall(load_stall),
		.load_item (load_item),
		.emit_valid(emit_valid),
		.emit_stall(emit_stall),
		.emit_item (emit_item)
	);

	// transform predictor state
	longint     vec_samples [0:63];
	logic       vec_signs [0:63];
	int         vec_loaded;
	int         length_reg;
	logic       inverse_reg;
	emit_item_t expected_emits [$];

	int mismatch_count;
	int samples_sent;
	int burst_left;
	int idle_cycles;
	int stall_style;
	int stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint norm_q16(input int k);
		case (k)
			0: return 65536;
			1: return 46341;
			2: return 32768;
			3: return 23170;
			4: return 16384;
			5: return 11585;
			default: return 8192;
		endcase
	endfunction

	function automatic int active_log2();
		return (length_reg > LOG_MAX) ? LOG_MAX : length_reg;
	endfunction

	function automatic void predict_transform();
		longint     work [0:63];
		longint     a;
		longint     b;
		longint     v;
		longint     r;
		int         k;
		int         n;
		int         span;
		int         base;
		int         j;
		int         i;
		emit_item_t want;
		k = active_log2();
		n = 1 << k;
		for (i = 0; i < n; i++) begin
			work[i] = vec_samples[i];
			if (!inverse_reg && vec_signs[i]) begin
				work[i] = -work[i];
			end
		end
		for (span = 1; span < n; span = span << 1) begin
			for (base = 0; base < n; base = base + 2 * span) begin
				for (j = 0; j < span; j++) begin
					a = work[base + j];
					b = work[base + j + span];
					work[base + j]        = a + b;
					work[base + j + span] = a - b;
				end
			end
		end
		for (i = 0; i < n; i++) begin
			v = work[i];
			if (inverse_reg && vec_signs[i]) begin
				v = -v;
			end
			r = (v * norm_q16(k) + 32768) >>> 16;
			if (r > 524287) begin
				r = 524287;
			end
			if (r < -524288) begin
				r = -524288;
			end
			want.result         = r[OUT_W-1:0];
			want.last_of_vector = (i == n - 1);
			expected_emits.push_back(want);
		end
	endfunction

	function automatic void record_sample(input load_item_t item);
		vec_samples[vec_loaded] = longint'(item.sample);
		vec_signs[vec_loaded]   = item.sign_negative;
		vec_loaded++;
		samples_sent++;
		if (vec_loaded >= (1 << active_log2())) begin
			predict_transform();
			vec_loaded = 0;
		end
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic negate);
		load_item_t item;
		item.sample        = value;
		item.sign_negative = negate;
		@(negedge clk);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				load_valid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		load_valid = 1'b1;
		load_item  = item;
		do @(posedge clk); while (load_stall);
		record_sample(item);
	endtask

	task automatic send_random_vector(input int n);
		repeat (n) send_sample(random_sample(), 1'($urandom));
	endtask

	task automatic release_load();
		@(negedge clk);
		load_valid = 1'b0;
	endtask

	task automatic wait_drain();
		release_load();
		while (expected_emits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
		wait_drain();
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		@(negedge clk);
		cfg_write = 1'b0;
		if (index == REG_LENGTH) begin
			length_reg = int'(value);
			vec_loaded = 0;
		end else begin
			inverse_reg = value[0];
		end
	endtask

	task automatic test_default_length();
		send_random_vector(1 << active_log2());
		release_load();
	endtask

	task automatic test_single_element();
		write_reg(REG_LENGTH, CFG_DATA_W'(0));
		write_reg(REG_MODE, MODE_FORWARD);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		release_load();
	endtask

	task automatic test_rounding_ties();
		write_reg(REG_LENGTH, CFG_DATA_W'(2));
		send_sample(16'sd1, 1'b0);
		repeat (3) send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd1, 1'b0);
		repeat (2) send_sample(16'sd0, 1'b0);
		release_load();
	endtask

	task automatic test_full_scale();
		write_reg(REG_LENGTH, CFG_DATA_W'(2));
		write_reg(REG_MODE, MODE_FORWARD);
		repeat (4) send_sample(16'sh8000, 1'b0);
		write_reg(REG_MODE, MODE_INVERSE);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(-16'sd1, 1'b1);
		release_load();
	endtask

	task automatic test_length_write_drops_partial();
		write_reg(REG_LENGTH, CFG_DATA_W'(2));
		send_random_vector(3);
		write_reg(REG_LENGTH, CFG_DATA_W'(1));
		send_random_vector(2);
		release_load();
	endtask

	task automatic test_mode_write_midvector();
		write_reg(REG_MODE, MODE_FORWARD);
		send_sample(16'sh1234, 1'b1);
		write_reg(REG_MODE, MODE_INVERSE);
		send_sample(-16'sh0567, 1'b1);
		release_load();
	endtask

	task automatic test_length_clamp();
		write_reg(REG_LENGTH, CFG_DATA_W'(7));
		write_reg(REG_MODE, MODE_FORWARD);
		send_random_vector(1 << active_log2());
		release_load();
	endtask

	task automatic test_random_vectors();
		int target;
		int k;
		int n;
		target = samples_sent + RANDOM_ITEMS;
		while (samples_sent < target) begin
			case ($urandom_range(0, 15))
				10, 11, 12: k = 4;
				13: k = 5;
				14: k = 6;
				15: k = 7;
				default: k = $urandom_range(0, 3);
			endcase
			write_reg(REG_LENGTH, CFG_DATA_W'(k));
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_MODE, ($urandom_range(0, 1) != 0) ? MODE_INVERSE : MODE_FORWARD);
			end
			n = 1 << active_log2();
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 7) == 0) begin
					wait_drain();
				end
				send_random_vector(n);
			end
			// leave a partial vector for the next length write to drop
			if (n > 1 && $urandom_range(0, 5) == 0) begin
				send_random_vector($urandom_range(1, n - 1));
			end
		end
		release_load();
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_style)
			0: emit_stall = 1'b0;
			1: emit_stall = ($urandom_range(0, 1) != 0);
			2: emit_stall = ($urandom_range(0, 7) == 0);
			default: emit_stall = ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		emit_item_t want;
		if (arst_n && emit_valid && !emit_stall) begin
			if (expected_emits.size() == 0) begin
				report_mismatch("unexpected result", longint'(emit_item.result), 0);
			end else begin
				want = expected_emits.pop_front();
				if (emit_item.result !== want.result) begin
					report_mismatch("result", longint'(emit_item.result), longint'(want.result));
				end
				if (emit_item.last_of_vector !== want.last_of_vector) begin
					report_mismatch("last_of_vector", longint'(emit_item.last_of_vector),
						longint'(want.last_of_vector));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((load_valid && !load_stall) || (emit_valid && !emit_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = REG_LENGTH;
		cfg_data       = '0;
		load_valid     = 1'b0;
		load_item      = '0;
		emit_stall     = 1'b0;
		stall_style    = 0;
		stall_left     = 0;
		idle_cycles    = 0;
		burst_left     = 0;
		mismatch_count = 0;
		samples_sent   = 0;
		vec_loaded     = 0;
		length_reg     = LOG_MAX;
		inverse_reg    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_length();
		test_single_element();
		test_rounding_ties();
		test_full_scale();
		test_length_write_drops_partial();
		test_mode_write_midvector();
		test_length_clamp();
		test_random_vectors();
		wait_drain();

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: randomized_hadamard_transform_top.f
+incdir+rtl
rtl/rht_pkg.sv
rtl/rht_ram.sv
rtl/rht_queue.sv
rtl/rht_front.sv
rtl/rht_back.sv
rtl/randomized_hadamard_transform_top.sv
bench/tb_randomized_hadamard_transform_top.sv
